@@ src/tlc_pkg.sv @@
package tlc_pkg;

  localparam int unsigned AddrW       = 32;
  localparam int unsigned CountW      = 32;
  localparam int unsigned OutcomeW    = 2;
  localparam int unsigned LfsrW       = 16;
  localparam int unsigned BlockBytesD = 64;
  localparam int unsigned L1SetsD     = 512;
  localparam int unsigned L1WaysD     = 2;
  localparam int unsigned L2SetsD     = 2048;
  localparam int unsigned L2WaysD     = 8;
  localparam logic [LfsrW-1:0] LfsrSeed = 16'hACE1;

  // Outcome codes of one access.
  localparam logic [OutcomeW-1:0] OutL1Hit  = 2'd0;
  localparam logic [OutcomeW-1:0] OutL2Hit  = 2'd1;
  localparam logic [OutcomeW-1:0] OutMissed = 2'd2;

  // One step of the victim LFSR (taps 16, 14, 13, 11, shifting right).
  function automatic logic [LfsrW-1:0] lfsr_step(input logic [LfsrW-1:0] s);
    logic b;
    b = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {b, s[LfsrW-1:1]};
  endfunction

endpackage

@@ src/tlc_ram.sv @@
module tlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/tlc_front.sv @@
module tlc_front import tlc_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [AddrW-1:0] address_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output logic [AddrW-1:0] q_address_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [AddrW-1:0] fifo_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             push;

  // Accept a transfer whenever the queue has room.
  assign stall_o     = (cnt_q == (PtrW+1)'(Depth));
  assign push        = valid_i && !stall_o;
  assign q_valid_o   = (cnt_q != '0);
  assign q_address_o = fifo_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_d = (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= address_i;
    end
  end

endmodule

@@ src/tlc_back.sv @@
module tlc_back import tlc_pkg::*; #(
  parameter int unsigned BlockBytes = BlockBytesD,
  parameter int unsigned L1Sets     = L1SetsD,
  parameter int unsigned L1Ways     = L1WaysD,
  parameter int unsigned L2Sets     = L2SetsD,
  parameter int unsigned L2Ways     = L2WaysD
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  logic [AddrW-1:0]    q_address_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [OutcomeW-1:0] outcome_o,
  output logic [CountW-1:0]   l1_hit_count_o,
  output logic [CountW-1:0]   l1_miss_count_o,
  output logic [CountW-1:0]   l2_hit_count_o,
  output logic [CountW-1:0]   l2_miss_count_o
);

  localparam int unsigned OffW  = $clog2(BlockBytes);
  localparam int unsigned BlkW  = AddrW - OffW;
  localparam int unsigned S1W   = (L1Sets > 1) ? $clog2(L1Sets) : 1;
  localparam int unsigned S1B   = $clog2(L1Sets);
  localparam int unsigned T1W   = BlkW - S1B;
  localparam int unsigned S2W   = (L2Sets > 1) ? $clog2(L2Sets) : 1;
  localparam int unsigned S2B   = $clog2(L2Sets);
  localparam int unsigned T2W   = BlkW - S2B;
  localparam int unsigned W1W   = (L1Ways > 1) ? $clog2(L1Ways) : 1;
  localparam int unsigned W2W   = (L2Ways > 1) ? $clog2(L2Ways) : 1;
  localparam int unsigned E1W   = L1Ways * (T1W + 1);
  localparam int unsigned E2W   = L2Ways * (T2W + 1);
  localparam int unsigned SetsMax = (L1Sets > L2Sets) ? L1Sets : L2Sets;
  localparam int unsigned ClrW  = $clog2(SetsMax + 1);

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StLook  = 3'b010,
    StFill  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [ClrW-1:0] clr_q;
  logic [BlkW-1:0] blk_q;
  logic [LfsrW-1:0] lfsr_q, lfsr_d;
  logic [CountW-1:0] c0_q, c1_q, c2_q, c3_q;
  logic              out_v_q;
  logic [OutcomeW-1:0] out_q;

  logic [S1W-1:0] s1, s1_q;
  logic [S2W-1:0] s2, s2_q;
  logic [T1W-1:0] t1_q;
  logic [T2W-1:0] t2_q;
  logic [E1W-1:0] row1, w1data;
  logic [E2W-1:0] row2, w2data;
  logic           we, start;
  logic [S1W-1:0] w1addr;
  logic [S2W-1:0] w2addr;

  // Set indices of the queued address; one row of each RAM holds a whole set.
  always_comb begin
    logic [BlkW-1:0] b;
    b  = q_address_i[AddrW-1:OffW];
    s1 = (L1Sets > 1) ? S1W'(b) : '0;
    s2 = (L2Sets > 1) ? S2W'(b) : '0;
  end

  assign start   = (state_q == StLook) && q_valid_i && !(out_v_q && stall_i);
  assign q_pop_o = start;

  tlc_ram #(.Width(E1W), .Depth(L1Sets)) u_l1 (
    .clk_i, .we_i(we), .waddr_i(w1addr), .wdata_i(w1data),
    .raddr_i(s1), .rdata_o(row1)
  );
  tlc_ram #(.Width(E2W), .Depth(L2Sets)) u_l2 (
    .clk_i, .we_i(we), .waddr_i(w2addr), .wdata_i(w2data),
    .raddr_i(s2), .rdata_o(row2)
  );

  // Lookup and fill of both levels from the registered rows.
  logic hit1, hit2, full1, full2;
  logic [W1W-1:0] free1, vic1;
  logic [W2W-1:0] free2, vic2;
  logic [LfsrW-1:0] lf_a, lf_b;
  logic [OutcomeW-1:0] outcome;

  always_comb begin
    hit1 = 1'b0; hit2 = 1'b0; full1 = 1'b1; full2 = 1'b1;
    free1 = '0; free2 = '0;
    for (int w = L1Ways-1; w >= 0; w--) begin
      if (row1[w*(T1W+1)+T1W] && row1[w*(T1W+1) +: T1W] == t1_q) hit1 = 1'b1;
      if (!row1[w*(T1W+1)+T1W]) begin
        full1 = 1'b0;
        free1 = W1W'(w);
      end
    end
    for (int w = L2Ways-1; w >= 0; w--) begin
      if (row2[w*(T2W+1)+T2W] && row2[w*(T2W+1) +: T2W] == t2_q) hit2 = 1'b1;
      if (!row2[w*(T2W+1)+T2W]) begin
        full2 = 1'b0;
        free2 = W2W'(w);
      end
    end
  end

  // Write data: zero rows during the clearing pass, otherwise the filled rows.
  always_comb begin
    logic fill2;
    fill2   = !hit1 && !hit2;
    outcome = hit1 ? OutL1Hit : (hit2 ? OutL2Hit : OutMissed);
    lf_a    = (fill2 && full2) ? lfsr_step(lfsr_q) : lfsr_q;
    lf_b    = (!hit1 && full1) ? lfsr_step(lf_a) : lf_a;
    vic2    = full2 ? W2W'(lf_a % LfsrW'(L2Ways)) : free2;
    vic1    = full1 ? W1W'(lf_b % LfsrW'(L1Ways)) : free1;
    w1data  = row1;
    w2data  = row2;
    if (state_q == StClear) begin
      w1data = '0;
      w2data = '0;
    end else begin
      if (!hit1) w1data[vic1*(T1W+1) +: (T1W+1)] = {1'b1, t1_q};
      if (fill2) w2data[vic2*(T2W+1) +: (T2W+1)] = {1'b1, t2_q};
    end
  end

  // Sequencer: clear pass, then lookup (RAM read) and fill (write back).
  always_comb begin
    state_d = state_q;
    lfsr_d  = lfsr_q;
    we      = 1'b0;
    w1addr  = s1_q;
    w2addr  = s2_q;
    unique case (state_q)
      StClear: begin
        we     = 1'b1;
        w1addr = S1W'(clr_q);
        w2addr = S2W'(clr_q);
        if (clr_q == ClrW'(SetsMax - 1)) state_d = StLook;
      end
      StLook: if (start) state_d = StFill;
      StFill: begin
        we      = 1'b1;
        lfsr_d  = lf_b;
        state_d = StLook;
      end
      default: state_d = StLook;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      lfsr_q  <= LfsrSeed;
      c0_q <= '0; c1_q <= '0; c2_q <= '0; c3_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lfsr_q  <= lfsr_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (out_v_q && !stall_i) out_v_q <= 1'b0;
      if (state_q == StFill) begin
        out_v_q <= 1'b1;
        c0_q <= c0_q + CountW'(hit1);
        c1_q <= c1_q + CountW'(!hit1);
        c2_q <= c2_q + CountW'(hit1 || hit2);
        c3_q <= c3_q + CountW'(!hit1 && !hit2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      blk_q <= q_address_i[AddrW-1:OffW];
      s1_q  <= s1;
      s2_q  <= s2;
    end
    if (state_q == StFill) out_q <= outcome;
  end

  assign t1_q = T1W'(blk_q >> S1B);
  assign t2_q = T2W'(blk_q >> S2B);

  assign valid_o         = out_v_q;
  assign outcome_o       = out_q;
  assign l1_hit_count_o  = c0_q;
  assign l1_miss_count_o = c1_q;
  assign l2_hit_count_o  = c2_q;
  assign l2_miss_count_o = c3_q;

endmodule

@@ src/two_level_cache_tag_lookup_unit.sv @@
// An accepted address waits in the two-entry front queue; the back end then
// reads the tag RAMs (lookup) and writes them back (fill), and valid_o rises
// after the fill. Queued addresses and output stalls delay it further. The
// back end takes no new address until that write-back is done; the tag RAMs
// hold one whole set per row. Reset: asynchronous, active low; afterwards a
// clearing pass over max(L1Sets, L2Sets) rows (2048 by default) precedes lookups.
module two_level_cache_tag_lookup_unit import tlc_pkg::*; #(
  parameter int unsigned BlockBytes = BlockBytesD,
  parameter int unsigned L1Sets     = L1SetsD,
  parameter int unsigned L1Ways     = L1WaysD,
  parameter int unsigned L2Sets     = L2SetsD,
  parameter int unsigned L2Ways     = L2WaysD
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [AddrW-1:0]    address_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [OutcomeW-1:0] outcome_o,
  output logic [CountW-1:0]   l1_hit_count_o,
  output logic [CountW-1:0]   l1_miss_count_o,
  output logic [CountW-1:0]   l2_hit_count_o,
  output logic [CountW-1:0]   l2_miss_count_o
);

  logic             q_valid, q_pop;
  logic [AddrW-1:0] q_address;

  tlc_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .address_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_address_o(q_address)
  );

  tlc_back #(
    .BlockBytes(BlockBytes), .L1Sets(L1Sets), .L1Ways(L1Ways),
    .L2Sets(L2Sets), .L2Ways(L2Ways)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_address_i(q_address), .valid_o, .stall_i, .outcome_o,
    .l1_hit_count_o, .l1_miss_count_o, .l2_hit_count_o, .l2_miss_count_o
  );

  // Outcome 3 never occurs on a delivered result.
  a_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (outcome_o != 2'd3)) else $error("bad outcome");

  // A new result bumps exactly the L1 hit or the L1 miss count.
  a_l1_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> ((l1_hit_count_o != $past(l1_hit_count_o)) !=
                        (l1_miss_count_o != $past(l1_miss_count_o))))
    else $error("L1 counters out of step");

  // A queue pop never happens with the queue empty.
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop of empty queue");

endmodule
